@@ design/sfd_pkg.sv @@
package sfd_pkg;

  // Fixed width of the number and factor ports
  localparam int unsigned DATA_W = 64;

  // First odd trial divisor and its square
  localparam int unsigned FIRST_DIV = 3;
  localparam int unsigned FIRST_SQ  = 9;

  typedef enum logic [1:0] {
    RES_TWO = 2'd0,
    RES_NUM = 2'd1,
    RES_DIV = 2'd2
  } res_sel_e;

  typedef struct packed {
    logic     load_num;
    logic     start_rem;
    logic     step_div;
    logic     load_res;
    res_sel_e res_sel;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_even;
    logic is_neg;
    logic sq_gt_num;
    logic rem_busy;
    logic rem_zero;
  } dp_stat_t;

endpackage

@@ design/sfd_rem.sv @@
module sfd_rem #(
  parameter int unsigned NUM_WIDTH = 64,
  parameter int unsigned DIV_WIDTH = 33
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_WIDTH-1:0] dividend_i,
  input  logic [DIV_WIDTH-1:0] divisor_i,
  output logic                 busy_o,
  output logic [DIV_WIDTH-1:0] rem_o
);

  localparam int unsigned CW = $clog2(NUM_WIDTH + 1);

  logic                 busy_q, busy_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [DIV_WIDTH-1:0] rem_q, rem_d;
  logic [NUM_WIDTH-1:0] shift_q, shift_d;
  logic [DIV_WIDTH:0]   trial;

  // Restoring division, one quotient bit per cycle; only the remainder is kept
  always_comb begin
    trial   = {rem_q, shift_q[NUM_WIDTH-1]};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    shift_d = shift_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = CW'(NUM_WIDTH);
      rem_d   = '0;
      shift_d = dividend_i;
    end else if (busy_q) begin
      shift_d = {shift_q[NUM_WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = DIV_WIDTH'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = DIV_WIDTH'(trial);
      end
      cnt_d  = cnt_q - CW'(1);
      busy_d = (cnt_q != CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    shift_q <= shift_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

@@ design/sfd_datapath.sv @@
module sfd_datapath import sfd_pkg::*; #(
  parameter int unsigned NUM_WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  input  logic [DATA_W-1:0] number_i,
  output logic [DATA_W-1:0] factor_o
);

  // divisor never passes sqrt(2^(NUM_WIDTH-1)) + 2
  localparam int unsigned DW  = NUM_WIDTH / 2 + 1;
  localparam int unsigned SQW = 2 * DW;

  logic [NUM_WIDTH-1:0] num_q;
  logic [DW-1:0]        div_q;
  logic [SQW-1:0]       sq_q;
  logic [DATA_W-1:0]    res_q, res_d;
  logic [DATA_W-1:0]    factor_q;
  logic [DW-1:0]        rem;
  logic                 rem_busy;

  sfd_rem #(
    .NUM_WIDTH (NUM_WIDTH),
    .DIV_WIDTH (DW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_rem),
    .dividend_i (num_q),
    .divisor_i  (div_q),
    .busy_o     (rem_busy),
    .rem_o      (rem)
  );

  always_comb begin
    case (cmd_i.res_sel)
      RES_TWO: res_d = DATA_W'(2);
      RES_NUM: res_d = DATA_W'($signed(num_q));
      RES_DIV: res_d = DATA_W'(div_q);
      default: res_d = DATA_W'($signed(num_q));
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_num) begin
      num_q <= number_i[NUM_WIDTH-1:0];
      div_q <= DW'(FIRST_DIV);
      sq_q  <= SQW'(FIRST_SQ);
    end else if (cmd_i.step_div) begin
      // (d+2)^2 = d^2 + 4(d+1)
      div_q <= div_q + DW'(2);
      sq_q  <= sq_q + SQW'({div_q + DW'(1), 2'b00});
    end
    if (cmd_i.load_res) begin
      res_q <= res_d;
    end
    if (cmd_i.load_out) begin
      factor_q <= res_q;
    end
  end

  assign stat_o.is_even   = ~num_q[0];
  assign stat_o.is_neg    = num_q[NUM_WIDTH-1];
  assign stat_o.sq_gt_num = (sq_q > SQW'(num_q));
  assign stat_o.rem_busy  = rem_busy;
  assign stat_o.rem_zero  = (rem == '0);
  assign factor_o         = factor_q;

endmodule

@@ design/sfd_ctrl.sv @@
module sfd_ctrl import sfd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CLASSIFY = 3'd1;
  localparam logic [2:0] S_CHECK    = 3'd2;
  localparam logic [2:0] S_DIVIDE   = 3'd3;
  localparam logic [2:0] S_FINISH   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{default: '0, res_sel: RES_NUM};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_num = 1'b1;
          state_d        = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        if (stat_i.is_even) begin
          cmd_o.load_res = 1'b1;
          cmd_o.res_sel  = RES_TWO;
          state_d        = S_FINISH;
        end else if (stat_i.is_neg) begin
          cmd_o.load_res = 1'b1;
          state_d        = S_FINISH;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.sq_gt_num) begin
          // no divisor up to the root: the number is prime (or one)
          cmd_o.load_res = 1'b1;
          state_d        = S_FINISH;
        end else begin
          cmd_o.start_rem = 1'b1;
          state_d         = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (!stat_i.rem_busy) begin
          if (stat_i.rem_zero) begin
            cmd_o.load_res = 1'b1;
            cmd_o.res_sel  = RES_DIV;
            state_d        = S_FINISH;
          end else begin
            cmd_o.step_div = 1'b1;
            state_d        = S_CHECK;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ design/smallest_factor_trial_division_core.sv @@
// Channel   Direction  Handshake                     Payload
// input     in         in_valid_i / in_stall_o       number_in_i  (64, signed)
// output    out        out_valid_o / out_stall_i     factor_out_o (64, signed)
//
// Even or negative numbers go from classification straight to the result; odd positive
// numbers take one remainder pass per divisor tried, stopping when a divisor divides
// or the square of the current divisor exceeds the number.
// One number at a time; the next is taken once the result is in the output register.
// Reset (rst_ni low, asynchronous) empties the controller and the output register.
// A stalled result holds in the output register; the controller waits behind it.
module smallest_factor_trial_division_core import sfd_pkg::*; #(
  parameter int unsigned NUM_WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [DATA_W-1:0] number_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] factor_out_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sfd_datapath #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .number_i (number_in_i),
    .factor_o (factor_out_o)
  );

endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  localparam int unsigned NUM_W      = 64;
  localparam int unsigned IDLE_LIMIT = 40000;
  localparam int unsigned GAP_MAX    = 14;

  typedef struct {
    logic [DATA_W-1:0] number;
    int unsigned       gap;
    bit                drain;
  } number_item_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic [DATA_W-1:0] number_in_i  = '0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic [DATA_W-1:0] factor_out_o;

  number_item_t      number_q[$];
  logic [DATA_W-1:0] factor_q[$];
  int unsigned       send_wait    = 0;
  int unsigned       stall_left   = 0;
  int unsigned       factors_seen = 0;
  bit                out_calm     = 1'b0;
  int unsigned       idle_cycles  = 0;
  int unsigned       err_count    = 0;

  smallest_factor_trial_division_core #(
    .NUM_WIDTH (NUM_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .number_in_i  (number_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .factor_out_o (factor_out_o)
  );

  always #6 clk_i = ~clk_i;

  // Trial division over odd divisors; only the low NUM_W bits count, sign-extended
  function automatic logic [DATA_W-1:0] smallest_factor(logic [DATA_W-1:0] raw);
    logic signed [DATA_W-1:0] n;
    logic [31:0]              d;
    n = raw << (DATA_W - NUM_W);
    n = n >>> (DATA_W - NUM_W);
    if (!n[0]) return DATA_W'(2);
    if (n[DATA_W-1]) return n;
    for (d = FIRST_DIV; ({32'd0, d} * {32'd0, d}) <= n; d += 2) begin
      if ((n % {32'd0, d}) == 0) return {32'd0, d};
    end
    return n;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  task automatic add_number(logic [DATA_W-1:0] number, bit calm, bit drain);
    number_item_t item;
    item.number = number;
    item.gap    = calm ? 0 : $urandom_range(0, GAP_MAX);
    item.drain  = drain;
    number_q.push_back(item);
  endtask

  // Driver: gap after each transfer, optional hold-off until all factors are back
  always @(posedge clk_i or negedge rst_ni) begin
    logic              busy;
    int unsigned       wait_n;
    number_item_t      item;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      number_in_i <= '0;
      send_wait   <= 0;
    end else begin
      busy   = in_valid_i;
      wait_n = send_wait;
      if (in_valid_i && !in_stall_o) begin
        factor_q.push_back(smallest_factor(number_in_i));
        busy = 1'b0;
      end
      if (!busy) begin
        if (wait_n != 0) begin
          wait_n--;
          in_valid_i <= 1'b0;
        end else if (number_q.size() != 0 &&
                     !(number_q[0].drain && factor_q.size() != 0)) begin
          item = number_q.pop_front();
          number_in_i <= item.number;
          in_valid_i  <= 1'b1;
          wait_n      = item.gap;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      send_wait <= wait_n;
    end
  end

  // Monitor: checks each factor transfer, then stalls for a drawn number of cycles
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned       hold;
    logic [DATA_W-1:0] want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      hold = stall_left;
      if (out_valid_o && !out_stall_i) begin
        if (factor_q.size() == 0) begin
          $error("unexpected result: factor_out actual %0d", $signed(factor_out_o));
          err_count++;
        end else begin
          want = factor_q.pop_front();
          if (factor_out_o !== want) begin
            $error("factor_out mismatch: expected %0d actual %0d",
                   $signed(want), $signed(factor_out_o));
            err_count++;
          end
        end
        factors_seen++;
        if (factors_seen % 20 == 0) out_calm = ($urandom_range(0, 2) == 0);
        hold = out_calm ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (hold != 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
      stall_left <= hold;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL smallest_factor_trial_division_core");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] m;
    int unsigned       p;
    bit                calm;

    // directed: field extremes, zero, one, negative odd, divisor at the sqrt bound
    add_number(64'd0, 1'b0, 1'b0);
    add_number(64'd1, 1'b0, 1'b0);
    add_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    add_number(64'd2, 1'b0, 1'b0);
    add_number(64'd3, 1'b0, 1'b0);
    add_number(64'd9, 1'b0, 1'b0);
    add_number(64'd11, 1'b0, 1'b0);
    add_number(64'd15, 1'b0, 1'b0);
    add_number(64'd25, 1'b0, 1'b0);
    add_number(64'd49, 1'b0, 1'b0);
    add_number(64'd121, 1'b0, 1'b0);
    add_number(64'd9409, 1'b0, 1'b0);
    add_number(64'd10403, 1'b0, 1'b1);
    add_number(64'd7919, 1'b0, 1'b0);
    add_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    add_number(64'h8000_0000_0000_0000, 1'b0, 1'b0);
    add_number(64'h7FFF_FFFF_FFFF_FFFE, 1'b0, 1'b0);
    add_number(64'h5555_5555_5555_5555, 1'b0, 1'b0);
    add_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
    add_number(64'hFFFF_FFFF_FFFF_FFFD, 1'b0, 1'b0);
    add_number(64'h8000_0000_0000_0001, 1'b0, 1'b0);
    add_number(64'h4000_0000_0000_0001, 1'b0, 1'b0);
    add_number(64'd3000000021, 1'b0, 1'b0);

    // random: odd positives are small or built with a small factor so the search stays short
    for (int i = 0; i < 100; i++) begin
      calm = (i >= 40 && i < 60);
      case ($urandom_range(0, 9))
        0, 1: r = rand_word() & ~64'd1;
        2:    r = rand_word() | 64'h8000_0000_0000_0001;
        3:    r = DATA_W'($urandom_range(0, 32767) * 2 + 1);
        default: begin
          p = $urandom_range(1, 99) * 2 + 1;
          m = (rand_word() >> 2) / p;
          m[0] = 1'b1;
          r = m * p;
        end
      endcase
      add_number(r, calm, i == 70);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (number_q.size() != 0 || in_valid_i || factor_q.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (err_count == 0) begin
      $display("PASS smallest_factor_trial_division_core");
    end else begin
      $display("FAIL smallest_factor_trial_division_core");
    end
    $finish;
  end

endmodule
